>>> rtl/cnse_pkg.sv
// Shared types and constants of the crop and nearest-neighbor scale engine.
package cnse_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 12;
   localparam int OIDX_W    = 9;
   localparam int STEP_W    = POS_W + FRAC_BITS;
   localparam int BYTE_W    = 8;
   localparam int NUM_CHAN  = 4;
   localparam int NUM_BYTES = 3;
   localparam int AXIS_CAP  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 12;
   localparam int QUEUE_DEPTH = 4;

   localparam int DEF_MAX_FRAME_DIM   = 2048;
   localparam int DEF_MAX_OUT_DIM     = 256;
   localparam int DEF_BYTES_PER_PIXEL = 3;
   localparam int DEF_CHANNELS        = 3;
   localparam int DEF_MIN_ZONE        = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_ZONE_LEFT    = 3'd2,
      REG_ZONE_TOP     = 3'd3,
      REG_ZONE_RIGHT   = 3'd4,
      REG_ZONE_BOTTOM  = 3'd5,
      REG_OUT_WIDTH    = 3'd6,
      REG_OUT_HEIGHT   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      STAT_PIXEL = 2'd0,
      STAT_OK    = 2'd1,
      STAT_BAD   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_X0,
      ST_X1,
      ST_Y0,
      ST_Y1,
      ST_EMIT,
      ST_ROW,
      ST_STATUS
   } back_state_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [10:0] zone_left;
      logic [10:0] zone_top;
      logic [11:0] zone_right;
      logic [11:0] zone_bottom;
      logic [8:0]  out_width;
      logic [8:0]  out_height;
   } csr_type;

   typedef struct packed {
      logic                              frame_start;
      logic                              end_row;
      logic                              end_frame;
      logic [POS_W-1:0]                  col;
      logic [POS_W-1:0]                  row;
      logic [NUM_CHAN-1:0][BYTE_W-1:0]   chan;
   } item_type;

endpackage

>>> rtl/crop_nearest_scale_engine_core.sv
// Top level of the crop and nearest-neighbor scale engine.
// Source pixels enter in raster order and are queued by the front end, so the
// pixel stream keeps flowing while the back end works, until the queue is full.
// The back end takes one request at a time: it picks it up, then scans the
// output column and row ranges (one mapper step per cycle, more steps when
// output indices are skipped), emits the results mapped to the pixel, and at
// row end moves the next output row past each row mapped so far. The first pixel
// of a frame with a valid zone also runs the 12.16 step divider, one quotient bit
// per cycle on each axis. A request outside a valid zone skips the scan. A frame's
// last pixel adds a status result (tuser 1 zone ok, 2
// invalid). Each result waits while the output register holds one not taken.
module crop_nearest_scale_engine_core import cnse_pkg::*; #(
   parameter int MAX_FRAME_DIM   = DEF_MAX_FRAME_DIM,
   parameter int MAX_OUT_DIM     = DEF_MAX_OUT_DIM,
   parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL,
   parameter int CHANNELS        = DEF_CHANNELS,
   parameter int MIN_ZONE        = DEF_MIN_ZONE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // pixel_byte0, pixel_byte1, pixel_byte2
   input  logic                           req_tuser,  // start_of_frame
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,  // out_col, out_row, chan0..chan3
   output logic [1:0]                     rsp_tuser,  // status
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DAT_W-1:0]           csr_data
);

   csr_type  csr_ff, csr_in;
   item_type push_item, head_item;
   logic     q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:  csr_in.frame_width  = csr_data;
            REG_FRAME_HEIGHT: csr_in.frame_height = csr_data;
            REG_ZONE_LEFT:    csr_in.zone_left    = csr_data[10:0];
            REG_ZONE_TOP:     csr_in.zone_top     = csr_data[10:0];
            REG_ZONE_RIGHT:   csr_in.zone_right   = csr_data;
            REG_ZONE_BOTTOM:  csr_in.zone_bottom  = csr_data;
            REG_OUT_WIDTH:    csr_in.out_width    = csr_data[8:0];
            REG_OUT_HEIGHT:   csr_in.out_height   = csr_data[8:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_width  <= 12'd640;
         csr_ff.frame_height <= 12'd480;
         csr_ff.zone_left    <= '0;
         csr_ff.zone_top     <= '0;
         csr_ff.zone_right   <= 12'd640;
         csr_ff.zone_bottom  <= 12'd480;
         csr_ff.out_width    <= 9'd32;
         csr_ff.out_height   <= 9'd20;
      end else begin
         csr_ff <= csr_in;
      end
   end

   cnse_front #(
      .MAX_FRAME_DIM   (MAX_FRAME_DIM),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
      .CHANNELS        (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr        (csr_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   cnse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   cnse_back #(
      .MAX_FRAME_DIM (MAX_FRAME_DIM),
      .MAX_OUT_DIM   (MAX_OUT_DIM),
      .MIN_ZONE      (MIN_ZONE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("request popped from empty queue");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_PIXEL) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("status result with data or without last");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("request accepted while queue full");

endmodule

>>> rtl/cnse_front.sv
// Front end: accepts source pixels, tracks the raster position and builds queue entries.
module cnse_front import cnse_pkg::*; #(
   parameter int MAX_FRAME_DIM   = DEF_MAX_FRAME_DIM,
   parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL,
   parameter int CHANNELS        = DEF_CHANNELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [NUM_BYTES*BYTE_W-1:0] req_tdata,
   input  logic                        req_tuser,
   input  csr_type                     csr,
   input  logic                        q_full,
   output logic                        q_push,
   output item_type                    q_item
);

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0] col_use, row_use, fw_clamp, fh_clamp;
   logic             end_row, end_frame;

   always_comb begin
      if (csr.frame_width == '0) fw_clamp = POS_W'(1);
      else if (32'(csr.frame_width) > MAX_FRAME_DIM) fw_clamp = POS_W'(MAX_FRAME_DIM);
      else fw_clamp = csr.frame_width;
      if (csr.frame_height == '0) fh_clamp = POS_W'(1);
      else if (32'(csr.frame_height) > MAX_FRAME_DIM) fh_clamp = POS_W'(MAX_FRAME_DIM);
      else fh_clamp = csr.frame_height;
   end

   assign col_use   = req_tuser ? '0 : col_ff;
   assign row_use   = req_tuser ? '0 : row_ff;
   assign end_row   = ({1'b0, col_use} + 1'b1) >= {1'b0, fw_clamp};
   assign end_frame = end_row && (({1'b0, row_use} + 1'b1) >= {1'b0, fh_clamp});

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.frame_start = (col_use == '0) && (row_use == '0);
      q_item.end_row     = end_row;
      q_item.end_frame   = end_frame;
      q_item.col         = col_use;
      q_item.row         = row_use;
      // channel c below CHANNELS copies source byte c modulo bytes per pixel, the rest are zero
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (c < CHANNELS)
            q_item.chan[c] = req_tdata[(c % BYTES_PER_PIXEL)*BYTE_W +: BYTE_W];
         else
            q_item.chan[c] = '0;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_frame ? '0 : row_use + 1'b1;
         end else begin
            col_in = col_use + 1'b1;
            row_in = row_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

>>> rtl/cnse_queue.sv
// Short request queue between the front end and the back end.
module cnse_queue import cnse_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign full      = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign empty     = cnt_ff == '0;
   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

>>> rtl/cnse_back.sv
// Back end: latches the frame steps, maps output coordinates and emits results.
module cnse_back import cnse_pkg::*; #(
   parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM,
   parameter int MAX_OUT_DIM   = DEF_MAX_OUT_DIM,
   parameter int MIN_ZONE      = DEF_MIN_ZONE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  csr_type                      csr,
   input  logic                         q_empty,
   input  item_type                     q_item,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [(NUM_CHAN+2)*BYTE_W-1:0] rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   output logic                         rsp_tlast
);

   localparam int CNT_W = $clog2(STEP_W);
   localparam int PROD_W = OIDX_W + STEP_W;
   localparam int MAP_W = PROD_W - FRAC_BITS + 1;

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;
   logic           zone_ok_ff, zone_ok_in;
   logic [STEP_W-1:0] col_step_ff, col_step_in, row_step_ff, row_step_in;
   logic [STEP_W-1:0] quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [OIDX_W-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OIDX_W-1:0] nxt_col_ff, nxt_col_in, nxt_row_ff, nxt_row_in;
   logic [OIDX_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [OIDX_W-1:0] xc_ff, xc_in, yc_ff, yc_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]               rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [NUM_CHAN-1:0][BYTE_W-1:0] rsp_chan_ff, rsp_chan_in;
   status_type                      rsp_status_ff, rsp_status_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [OIDX_W-1:0] ow_cap, oh_cap;
   logic [POS_W-1:0]  zw, zh;
   logic              frame_ok;
   logic [OIDX_W-1:0] map_idx;
   logic [STEP_W-1:0] map_step;
   logic [10:0]       map_base;
   logic [POS_W-1:0]  map_tgt;
   logic [PROD_W-1:0] prod;
   logic [MAP_W-1:0]  map_pos, tgt_ext;
   logic              pos_lt, pos_eq, pos_le;
   logic [OIDX_W:0]   rsx, rsy, dsx, dsy;
   logic              gex, gey;
   logic              slot_free, cont_x0, cont_x1, cont_y0, cont_y1, cont_row;
   logic              last_x, last_y;

   always_comb begin
      ow_cap = (32'(csr.out_width) > MAX_OUT_DIM) ? OIDX_W'(MAX_OUT_DIM) : csr.out_width;
      oh_cap = (32'(csr.out_height) > MAX_OUT_DIM) ? OIDX_W'(MAX_OUT_DIM) : csr.out_height;
   end

   assign zw = csr.zone_right - {1'b0, csr.zone_left};
   assign zh = csr.zone_bottom - {1'b0, csr.zone_top};

   // zone check done at frame start
   assign frame_ok = (csr.frame_width != '0) && (32'(csr.frame_width) <= MAX_FRAME_DIM)
      && (csr.frame_height != '0) && (32'(csr.frame_height) <= MAX_FRAME_DIM)
      && (csr.zone_right <= csr.frame_width) && (csr.zone_bottom <= csr.frame_height)
      && ({1'b0, csr.zone_left} < csr.zone_right) && ({1'b0, csr.zone_top} < csr.zone_bottom)
      && (csr.out_width != '0) && (32'(csr.out_width) <= MAX_OUT_DIM)
      && (csr.out_height != '0) && (32'(csr.out_height) <= MAX_OUT_DIM)
      && (32'(zw) >= MIN_ZONE) && (32'(zh) >= MIN_ZONE)
      && ({zw, 2'b00} >= (POS_W+2)'(csr.out_width))
      && ({zh, 2'b00} >= (POS_W+2)'(csr.out_height));

   // shared coordinate mapper
   always_comb begin
      map_idx  = x0_ff;
      map_step = col_step_ff;
      map_base = csr.zone_left;
      map_tgt  = item_ff.col;
      case (state_ff)
         ST_X1: map_idx = x1_ff;
         ST_Y0: begin
            map_idx  = y0_ff;
            map_step = row_step_ff;
            map_base = csr.zone_top;
            map_tgt  = item_ff.row;
         end
         ST_Y1: begin
            map_idx  = y1_ff;
            map_step = row_step_ff;
            map_base = csr.zone_top;
            map_tgt  = item_ff.row;
         end
         ST_ROW: begin
            map_idx  = nxt_row_ff;
            map_step = row_step_ff;
            map_base = csr.zone_top;
            map_tgt  = item_ff.row;
         end
         default: map_idx = x0_ff;
      endcase
   end

   assign prod    = PROD_W'(map_idx) * PROD_W'(map_step);
   assign map_pos = MAP_W'(map_base) + MAP_W'(prod[PROD_W-1:FRAC_BITS]);
   assign tgt_ext = MAP_W'(map_tgt);
   assign pos_lt  = map_pos < tgt_ext;
   assign pos_eq  = map_pos == tgt_ext;
   assign pos_le  = map_pos <= tgt_ext;

   // one quotient bit per cycle on each axis
   assign rsx = {rem_x_ff, quo_x_ff[STEP_W-1]};
   assign rsy = {rem_y_ff, quo_y_ff[STEP_W-1]};
   assign gex = rsx >= {1'b0, csr.out_width};
   assign gey = rsy >= {1'b0, csr.out_height};
   assign dsx = gex ? rsx - {1'b0, csr.out_width} : rsx;
   assign dsy = gey ? rsy - {1'b0, csr.out_height} : rsy;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cont_x0  = (x0_ff < ow_cap) && pos_lt;
   assign cont_x1  = (x1_ff < ow_cap) && ((x1_ff - x0_ff) < OIDX_W'(AXIS_CAP)) && pos_eq;
   assign cont_y0  = (y0_ff < oh_cap) && pos_lt;
   assign cont_y1  = (y1_ff < oh_cap) && ((y1_ff - y0_ff) < OIDX_W'(AXIS_CAP)) && pos_eq;
   assign cont_row = zone_ok_ff && (nxt_row_ff < oh_cap) && pos_le;
   assign last_x   = xc_ff == x1_ff - 1'b1;
   assign last_y   = yc_ff == y1_ff - 1'b1;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_item.frame_start && frame_ok) state_in = ST_DIV;
               else if (!q_item.frame_start && zone_ok_ff) state_in = ST_X0;
               else if (q_item.end_row) state_in = ST_ROW;
            end
         end
         ST_DIV: if (cnt_ff == CNT_W'(STEP_W - 1)) state_in = ST_X0;
         ST_X0:  if (!cont_x0) state_in = ST_X1;
         ST_X1:  if (!cont_x1) state_in = ST_Y0;
         ST_Y0:  if (!cont_y0) state_in = ST_Y1;
         ST_Y1: begin
            if (!cont_y1) begin
               if ((x1_ff != x0_ff) && (y1_ff != y0_ff)) state_in = ST_EMIT;
               else state_in = item_ff.end_row ? ST_ROW : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free && last_x && last_y)
               state_in = item_ff.end_row ? ST_ROW : ST_IDLE;
         end
         ST_ROW: if (!cont_row) state_in = item_ff.end_frame ? ST_STATUS : ST_IDLE;
         ST_STATUS: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      item_in     = item_ff;
      zone_ok_in  = zone_ok_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      quo_x_in    = quo_x_ff;
      quo_y_in    = quo_y_ff;
      rem_x_in    = rem_x_ff;
      rem_y_in    = rem_y_ff;
      cnt_in      = cnt_ff;
      nxt_col_in  = nxt_col_ff;
      nxt_row_in  = nxt_row_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y0_in       = y0_ff;
      y1_in       = y1_ff;
      xc_in       = xc_ff;
      yc_in       = yc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               item_in = q_item;
               if (q_item.frame_start) begin
                  zone_ok_in  = frame_ok;
                  nxt_col_in  = '0;
                  nxt_row_in  = '0;
                  x0_in       = '0;
                  y0_in       = '0;
                  col_step_in = '0;
                  row_step_in = '0;
                  quo_x_in    = {zw, {FRAC_BITS{1'b0}}};
                  quo_y_in    = {zh, {FRAC_BITS{1'b0}}};
                  rem_x_in    = '0;
                  rem_y_in    = '0;
                  cnt_in      = '0;
               end else begin
                  x0_in = nxt_col_ff;
                  y0_in = nxt_row_ff;
               end
            end
         end
         ST_DIV: begin
            quo_x_in = {quo_x_ff[STEP_W-2:0], gex};
            quo_y_in = {quo_y_ff[STEP_W-2:0], gey};
            rem_x_in = dsx[OIDX_W-1:0];
            rem_y_in = dsy[OIDX_W-1:0];
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEP_W - 1)) begin
               col_step_in = {quo_x_ff[STEP_W-2:0], gex};
               row_step_in = {quo_y_ff[STEP_W-2:0], gey};
            end
         end
         ST_X0: begin
            if (cont_x0) x0_in = x0_ff + 1'b1;
            else x1_in = x0_ff;
         end
         ST_X1: if (cont_x1) x1_in = x1_ff + 1'b1;
         ST_Y0: begin
            if (cont_y0) y0_in = y0_ff + 1'b1;
            else y1_in = y0_ff;
         end
         ST_Y1: begin
            if (cont_y1) begin
               y1_in = y1_ff + 1'b1;
            end else begin
               nxt_col_in = x1_ff;
               xc_in      = x0_ff;
               yc_in      = y0_ff;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_col_in    = xc_ff[BYTE_W-1:0];
               rsp_row_in    = yc_ff[BYTE_W-1:0];
               rsp_chan_in   = item_ff.chan;
               rsp_status_in = STAT_PIXEL;
               rsp_last_in   = last_x && last_y && !item_ff.end_frame;
               if (last_x) begin
                  xc_in = x0_ff;
                  yc_in = yc_ff + 1'b1;
               end else begin
                  xc_in = xc_ff + 1'b1;
               end
            end
         end
         ST_ROW: begin
            if (cont_row) begin
               nxt_row_in = nxt_row_ff + 1'b1;
            end else begin
               nxt_col_in = '0;
               if (item_ff.end_frame) nxt_row_in = '0;
            end
         end
         ST_STATUS: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_col_in    = '0;
               rsp_row_in    = '0;
               rsp_chan_in   = '0;
               rsp_status_in = zone_ok_ff ? STAT_OK : STAT_BAD;
               rsp_last_in   = 1'b1;
            end
         end
         default: item_in = item_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zone_ok_ff   <= 1'b0;
         col_step_ff  <= '0;
         row_step_ff  <= '0;
         nxt_col_ff   <= '0;
         nxt_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zone_ok_ff   <= zone_ok_in;
         col_step_ff  <= col_step_in;
         row_step_ff  <= row_step_in;
         nxt_col_ff   <= nxt_col_in;
         nxt_row_ff   <= nxt_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      quo_x_ff      <= quo_x_in;
      quo_y_ff      <= quo_y_in;
      rem_x_ff      <= rem_x_in;
      rem_y_ff      <= rem_y_in;
      cnt_ff        <= cnt_in;
      x0_ff         <= x0_in;
      x1_ff         <= x1_in;
      y0_ff         <= y0_in;
      y1_ff         <= y1_in;
      xc_ff         <= xc_in;
      yc_ff         <= yc_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_chan_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> tb/sv/tb_crop_nearest_scale_engine_core.sv
// Self-checking testbench of the crop and nearest-neighbor scale engine core.
module tb_crop_nearest_scale_engine_core;
   import cnse_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 800;
   localparam int TARGET_PIXELS  = 400;

   typedef struct {
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] chan [NUM_CHAN];
      logic [1:0] status;
      logic       last;
   } scaled_pixel_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   scaled_pixel_type pending_pixels[$];
   int            error_count;
   int            idle_cycles;
   int            rsp_stall_left;
   int            pixels_sent;
   bit            no_idle;

   // predictor copy of the registers and the frame state
   int unsigned   geom_reg [8];
   int unsigned   raster_col, raster_row, col_step_q, row_step_q;
   int unsigned   next_col_q, next_row_q;
   bit            zone_valid_q;

   crop_nearest_scale_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned mapped_pos(int unsigned base, int unsigned step,
                                              int unsigned idx);
      longint unsigned prod;
      prod = longint'(idx) * longint'(step);
      return base + int'(prod >> FRAC_BITS);
   endfunction

   function automatic void latch_frame_geometry();
      int unsigned fw, fh, zl, zt, zr, zb, ow, oh;
      bit ok;
      fw = geom_reg[REG_FRAME_WIDTH];  fh = geom_reg[REG_FRAME_HEIGHT];
      zl = geom_reg[REG_ZONE_LEFT];    zt = geom_reg[REG_ZONE_TOP];
      zr = geom_reg[REG_ZONE_RIGHT];   zb = geom_reg[REG_ZONE_BOTTOM];
      ow = geom_reg[REG_OUT_WIDTH];    oh = geom_reg[REG_OUT_HEIGHT];
      ok = fw >= 1 && fw <= DEF_MAX_FRAME_DIM && fh >= 1 && fh <= DEF_MAX_FRAME_DIM
           && zr <= fw && zb <= fh && zl < zr && zt < zb
           && ow >= 1 && ow <= DEF_MAX_OUT_DIM && oh >= 1 && oh <= DEF_MAX_OUT_DIM;
      if (ok)
         ok = (zr - zl) >= DEF_MIN_ZONE && (zb - zt) >= DEF_MIN_ZONE
              && 4 * (zr - zl) >= ow && 4 * (zb - zt) >= oh;
      zone_valid_q = ok;
      col_step_q = ok ? ((zr - zl) << FRAC_BITS) / ow : 0;
      row_step_q = ok ? ((zb - zt) << FRAC_BITS) / oh : 0;
      next_col_q = 0;
      next_row_q = 0;
   endfunction

   function automatic void predict_pixel(bit sof, logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2);
      int unsigned fw, fh, ow, oh, x0, x1, y0, y1;
      logic [7:0] src_bytes [NUM_BYTES];
      scaled_pixel_type res;
      scaled_pixel_type batch[$];
      bit end_row, end_frame;
      fw = clamp_dim(geom_reg[REG_FRAME_WIDTH], DEF_MAX_FRAME_DIM);
      fh = clamp_dim(geom_reg[REG_FRAME_HEIGHT], DEF_MAX_FRAME_DIM);
      ow = geom_reg[REG_OUT_WIDTH] > DEF_MAX_OUT_DIM ? DEF_MAX_OUT_DIM
                                                     : geom_reg[REG_OUT_WIDTH];
      oh = geom_reg[REG_OUT_HEIGHT] > DEF_MAX_OUT_DIM ? DEF_MAX_OUT_DIM
                                                      : geom_reg[REG_OUT_HEIGHT];
      src_bytes[0] = b0; src_bytes[1] = b1; src_bytes[2] = b2;
      for (int c = 0; c < NUM_CHAN; c++)
         res.chan[c] = (c < DEF_CHANNELS) ? src_bytes[c % DEF_BYTES_PER_PIXEL] : 8'd0;
      res.status = STAT_PIXEL;
      res.last = 1'b0;
      if (sof) begin
         raster_col = 0;
         raster_row = 0;
      end
      if (raster_col == 0 && raster_row == 0) latch_frame_geometry();
      if (zone_valid_q) begin
         x0 = next_col_q;
         y0 = next_row_q;
         while (x0 < ow && mapped_pos(geom_reg[REG_ZONE_LEFT], col_step_q, x0) < raster_col)
            x0++;
         x1 = x0;
         while (x1 < ow && x1 - x0 < AXIS_CAP
                && mapped_pos(geom_reg[REG_ZONE_LEFT], col_step_q, x1) == raster_col)
            x1++;
         while (y0 < oh && mapped_pos(geom_reg[REG_ZONE_TOP], row_step_q, y0) < raster_row)
            y0++;
         y1 = y0;
         while (y1 < oh && y1 - y0 < AXIS_CAP
                && mapped_pos(geom_reg[REG_ZONE_TOP], row_step_q, y1) == raster_row)
            y1++;
         for (int unsigned y = y0; y < y1; y++)
            for (int unsigned x = x0; x < x1; x++) begin
               res.col = x[7:0];
               res.row = y[7:0];
               batch = {batch, res};
            end
         next_col_q = x1;
      end
      end_row = raster_col + 1 >= fw;
      end_frame = end_row && raster_row + 1 >= fh;
      if (end_row) begin
         if (zone_valid_q)
            while (next_row_q < oh
                   && mapped_pos(geom_reg[REG_ZONE_TOP], row_step_q, next_row_q) <= raster_row)
               next_row_q++;
         next_col_q = 0;
         raster_col = 0;
         raster_row = end_frame ? 0 : raster_row + 1;
      end else begin
         raster_col++;
      end
      if (end_frame) begin
         next_row_q = 0;
         res.col = 8'd0;
         res.row = 8'd0;
         for (int c = 0; c < NUM_CHAN; c++) res.chan[c] = 8'd0;
         res.status = zone_valid_q ? STAT_OK : STAT_BAD;
         batch = {batch, res};
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      pending_pixels = {pending_pixels, batch};
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result side: random stall per result, check each accepted result
   always @(posedge clock) begin
      scaled_pixel_type want;
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_tuser, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.col) report_mismatch("out_col", rsp_tdata[7:0], want.col);
            if (rsp_tdata[15:8] !== want.row) report_mismatch("out_row", rsp_tdata[15:8], want.row);
            for (int c = 0; c < NUM_CHAN; c++)
               if (rsp_tdata[16 + 8 * c +: 8] !== want.chan[c])
                  report_mismatch($sformatf("chan%0d", c), rsp_tdata[16 + 8 * c +: 8],
                                  want.chan[c]);
            if (rsp_tuser !== want.status) report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
         end
         stall = no_idle ? 0 : $urandom_range(0, 10);
         rsp_tready <= (stall == 0);
         rsp_stall_left <= stall;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= (rsp_stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // count cycles where work is outstanding but nothing moves
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (pending_pixels.size() > 0 || req_tvalid || csr_valid) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_write(reg_index_type idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DAT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx) inside
         REG_ZONE_LEFT, REG_ZONE_TOP:     geom_reg[idx] = value & 32'h7FF;
         REG_OUT_WIDTH, REG_OUT_HEIGHT:   geom_reg[idx] = value & 32'h1FF;
         default:                         geom_reg[idx] = value & 32'hFFF;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned fw, int unsigned fh, int unsigned zl,
                               int unsigned zt, int unsigned zr, int unsigned zb,
                               int unsigned ow, int unsigned oh);
      csr_write(REG_FRAME_WIDTH, fw);
      csr_write(REG_FRAME_HEIGHT, fh);
      csr_write(REG_ZONE_LEFT, zl);
      csr_write(REG_ZONE_TOP, zt);
      csr_write(REG_ZONE_RIGHT, zr);
      csr_write(REG_ZONE_BOTTOM, zb);
      csr_write(REG_OUT_WIDTH, ow);
      csr_write(REG_OUT_HEIGHT, oh);
   endtask

   task automatic send_pixel(bit sof, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= sof;
      req_tdata <= {b2, b1, b0};
      do @(posedge clock); while (!req_tready);
      predict_pixel(sof, b0, b1, b2);
      pixels_sent++;
   endtask

   task automatic send_random_pixels(int count, bit first_sof);
      for (int i = 0; i < count; i++)
         send_pixel(i == 0 ? first_sof : ($urandom_range(0, 63) == 0), $urandom,
                    $urandom, $urandom);
   endtask

   // hold off until the block has drained everything, including silent pixels
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_geometry();
      send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
      send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(1'b0, 8'hA5, 8'h5A, 8'h3C);
      send_pixel(1'b1, 8'h12, 8'h34, 8'h56);
      settle();
   endtask

   task automatic test_single_pixel_frames();
      // zero frame sides clamp to one pixel: every request ends a frame
      set_geometry(0, 0, 0, 0, 1, 1, 1, 1);
      send_pixel(1'b0, 8'h01, 8'h02, 8'h03);
      send_pixel(1'b1, 8'hFE, 8'hFD, 8'hFC);
      send_pixel(1'b0, 8'h80, 8'h40, 8'h20);
      settle();
   endtask

   task automatic test_register_extremes();
      set_geometry(4095, 4095, 2047, 2047, 4095, 4095, 511, 511);
      send_pixel(1'b1, 8'h11, 8'h22, 8'h33);
      send_pixel(1'b0, 8'h44, 8'h55, 8'h66);
      settle();
      set_geometry(2048, 2048, 2040, 2040, 2048, 2048, 256, 256);
      send_pixel(1'b1, 8'h77, 8'h88, 8'h99);
      send_pixel(1'b0, 8'hAA, 8'hBB, 8'hCC);
      settle();
   endtask

   task automatic test_max_upscale();
      // 8x8 zone to 32x32: each source pixel fans out to a 4x4 block
      set_geometry(8, 8, 0, 0, 8, 8, 32, 32);
      no_idle = 1'b1;
      send_random_pixels(5, 1'b1);
      no_idle = 1'b0;
      send_random_pixels(4, 1'b0);
      settle();
   endtask

   task automatic test_random_frames();
      int unsigned zw, zh, fw, fh, zl, zt, ow, oh, frames;
      int n;
      while (pixels_sent < TARGET_PIXELS) begin
         zw = $urandom_range(8, 12);
         zh = $urandom_range(8, 12);
         fw = zw + $urandom_range(0, 3);
         fh = zh + $urandom_range(0, 3);
         zl = $urandom_range(0, fw - zw);
         zt = $urandom_range(0, fh - zh);
         ow = $urandom_range(0, 1) ? $urandom_range(1, zw) : $urandom_range(1, 4 * zw);
         oh = $urandom_range(0, 1) ? $urandom_range(1, zh) : $urandom_range(1, 4 * zh);
         case ($urandom_range(0, 9))
            0: ow = 4 * zw + $urandom_range(1, 3);
            1: zl = fw - zw + 1;
            2: begin zw = 7; zl = 0; end
            3: oh = 0;
            default: ;
         endcase
         set_geometry(fw, fh, zl, zt, zl + zw, zt + zh, ow, oh);
         no_idle = ($urandom_range(0, 3) == 0);
         frames = $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            // now and then cut a frame short; the next phase restarts it
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, fw * fh) : fw * fh;
            if (n > TARGET_PIXELS - pixels_sent) n = TARGET_PIXELS - pixels_sent;
            if (n > 0) send_random_pixels(n, 1'b1);
         end
         no_idle = 1'b0;
         settle();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_data = '0;
      error_count = 0;
      pixels_sent = 0;
      no_idle = 1'b0;
      geom_reg = '{640, 480, 0, 0, 640, 480, 32, 20};
      raster_col = 0; raster_row = 0; col_step_q = 0; row_step_q = 0;
      next_col_q = 0; next_row_q = 0; zone_valid_q = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_single_pixel_frames();
      test_register_extremes();
      test_max_upscale();
      test_random_frames();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
